>>> rtl/pmt_pkg.sv
// Package for the PS/2 mouse packet tracker: item kinds, packet phase codes,
// tracker state and result types, and saturation helpers. No dependencies.
package pmt_pkg;

  localparam int unsigned CUR_W   = 18;
  localparam int unsigned DELTA_W = 16;
  localparam int unsigned POS_W   = 16;
  localparam int unsigned NEW_W   = 17;
  localparam int unsigned BTN_W   = 3;

  localparam logic [7:0]  SYNC_MASK = 8'h08;
  localparam logic [15:0] MAX_X_RST = 16'd800;
  localparam logic [15:0] MAX_Y_RST = 16'd600;

  // Configuration register indexes.
  localparam logic REG_MAX_X = 1'b0;
  localparam logic REG_MAX_Y = 1'b1;

  typedef enum logic [1:0] {
    KIND_MOUSE_BYTE = 2'd0,
    KIND_FRAME_END  = 2'd1,
    KIND_SET_POS    = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    PH_HEADER = 3'b001,
    PH_XMOVE  = 3'b010,
    PH_YMOVE  = 3'b100
  } phase_t;

  typedef struct packed {
    phase_t                     phase;
    logic [BTN_W-1:0]           hdr_btn;
    logic [7:0]                 xmove;
    logic [BTN_W-1:0]           levels;
    logic [BTN_W-1:0]           press;
    logic [BTN_W-1:0]           release_m;
    logic signed [CUR_W-1:0]    cur_x;
    logic signed [CUR_W-1:0]    cur_y;
    logic signed [DELTA_W-1:0]  frame_dx;
    logic signed [DELTA_W-1:0]  frame_dy;
  } trk_state_t;

  typedef struct packed {
    logic [BTN_W-1:0]           released;
    logic [BTN_W-1:0]           pressed;
    logic [BTN_W-1:0]           down;
    logic signed [DELTA_W-1:0]  delta_y;
    logic signed [DELTA_W-1:0]  delta_x;
    logic [POS_W-1:0]           pos_y;
    logic [POS_W-1:0]           pos_x;
  } frame_rpt_t;

  // Saturate a 19-bit signed sum to the 18-bit cursor range.
  function automatic logic signed [CUR_W-1:0] sat_cur(input logic signed [CUR_W:0] v);
    logic signed [CUR_W-1:0] r;
    if (v[CUR_W] != v[CUR_W-1]) begin
      r = v[CUR_W] ? {1'b1, {(CUR_W-1){1'b0}}} : {1'b0, {(CUR_W-1){1'b1}}};
    end else begin
      r = v[CUR_W-1:0];
    end
    return r;
  endfunction

  // Saturate a 17-bit signed sum to the 16-bit delta range.
  function automatic logic signed [DELTA_W-1:0] sat_delta(
    input logic signed [DELTA_W:0] v
  );
    logic signed [DELTA_W-1:0] r;
    if (v[DELTA_W] != v[DELTA_W-1]) begin
      r = v[DELTA_W] ? {1'b1, {(DELTA_W-1){1'b0}}} : {1'b0, {(DELTA_W-1){1'b1}}};
    end else begin
      r = v[DELTA_W-1:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/pmt_update.sv
// Next-state and frame report logic of the mouse packet tracker.
// Pure combinational; depends on pmt_pkg.
module pmt_update (
  input  pmt_pkg::trk_state_t          cur,
  input  pmt_pkg::kind_t               kind,
  input  logic [7:0]                   data_byte,
  input  logic signed [pmt_pkg::NEW_W-1:0] new_x,
  input  logic signed [pmt_pkg::NEW_W-1:0] new_y,
  input  logic [pmt_pkg::POS_W-1:0]    max_x,
  input  logic [pmt_pkg::POS_W-1:0]    max_y,
  output pmt_pkg::trk_state_t          nxt,
  output logic                         rpt_vld,
  output pmt_pkg::frame_rpt_t          rpt
);

  logic signed [pmt_pkg::CUR_W:0]   dx_c, dy_c;
  logic signed [pmt_pkg::DELTA_W:0] dx_d, dy_d;
  logic [pmt_pkg::POS_W-1:0]        clamp_x, clamp_y;

  // Movement bytes sign-extended to the cursor and delta adder widths.
  assign dx_c = {{(pmt_pkg::CUR_W-7){cur.xmove[7]}}, cur.xmove};
  assign dy_c = {{(pmt_pkg::CUR_W-7){data_byte[7]}}, data_byte};
  assign dx_d = {{(pmt_pkg::DELTA_W-7){cur.xmove[7]}}, cur.xmove};
  assign dy_d = {{(pmt_pkg::DELTA_W-7){data_byte[7]}}, data_byte};

  // Cursor clamped to 0..max; a negative cursor goes to zero.
  always_comb begin
    if (cur.cur_x[pmt_pkg::CUR_W-1]) begin
      clamp_x = '0;
    end else if (cur.cur_x[pmt_pkg::CUR_W-2:0] > {1'b0, max_x}) begin
      clamp_x = max_x;
    end else begin
      clamp_x = cur.cur_x[pmt_pkg::POS_W-1:0];
    end
    if (cur.cur_y[pmt_pkg::CUR_W-1]) begin
      clamp_y = '0;
    end else if (cur.cur_y[pmt_pkg::CUR_W-2:0] > {1'b0, max_y}) begin
      clamp_y = max_y;
    end else begin
      clamp_y = cur.cur_y[pmt_pkg::POS_W-1:0];
    end
  end

  always_comb begin
    nxt     = cur;
    rpt_vld = 1'b0;
    rpt.pos_x    = clamp_x;
    rpt.pos_y    = clamp_y;
    rpt.delta_x  = cur.frame_dx;
    rpt.delta_y  = cur.frame_dy;
    rpt.down     = cur.levels;
    rpt.pressed  = cur.press;
    rpt.released = cur.release_m;
    unique case (kind)
      pmt_pkg::KIND_MOUSE_BYTE: begin
        unique case (cur.phase)
          pmt_pkg::PH_HEADER: begin
            if ((data_byte & pmt_pkg::SYNC_MASK) != 8'h00) begin
              nxt.hdr_btn = data_byte[pmt_pkg::BTN_W-1:0];
              nxt.phase   = pmt_pkg::PH_XMOVE;
            end
          end
          pmt_pkg::PH_XMOVE: begin
            nxt.xmove = data_byte;
            nxt.phase = pmt_pkg::PH_YMOVE;
          end
          default: begin
            // Third byte closes the packet; y grows downward on screen.
            nxt.phase     = pmt_pkg::PH_HEADER;
            nxt.press     = cur.hdr_btn & ~cur.levels;
            nxt.release_m = ~cur.hdr_btn & cur.levels;
            nxt.levels    = cur.hdr_btn;
            nxt.frame_dx  = pmt_pkg::sat_delta({cur.frame_dx[15], cur.frame_dx} + dx_d);
            nxt.frame_dy  = pmt_pkg::sat_delta({cur.frame_dy[15], cur.frame_dy} + dy_d);
            nxt.cur_x     = pmt_pkg::sat_cur({cur.cur_x[17], cur.cur_x} + dx_c);
            nxt.cur_y     = pmt_pkg::sat_cur({cur.cur_y[17], cur.cur_y} - dy_c);
          end
        endcase
      end
      pmt_pkg::KIND_FRAME_END: begin
        rpt_vld       = 1'b1;
        nxt.cur_x     = {2'b00, clamp_x};
        nxt.cur_y     = {2'b00, clamp_y};
        nxt.frame_dx  = '0;
        nxt.frame_dy  = '0;
        nxt.press     = '0;
        nxt.release_m = '0;
      end
      pmt_pkg::KIND_SET_POS: begin
        nxt.cur_x = {new_x[pmt_pkg::NEW_W-1], new_x};
        nxt.cur_y = {new_y[pmt_pkg::NEW_W-1], new_y};
      end
      default: begin
        // Reserved kind: no effect.
      end
    endcase
  end

endmodule

>>> rtl/ps2_mouse_packet_tracker.sv
// Top level of the PS/2 mouse packet tracker: stream ports, APB-style
// configuration registers, input, state and result registers.
// Depends on pmt_pkg and pmt_update.

// The tracker takes one input transfer per clock, for every kind, with no
// bubbles while no frame end item is held. An accepted item waits in the
// input register and is applied to the tracker state as it leaves it; a frame
// end report is then registered in the result register for output. Only frame
// end items (tuser kind 1) produce an output transfer; mouse bytes (kind 0)
// and set-position items (kind 2) only change state, and kind 3 is ignored.
// The result register decouples the two sides: mouse bytes and cursor loads
// keep flowing while a report waits, and only a frame end item that arrives
// behind a stalled report is held, which holds off the items behind it in
// turn. Mouse bytes are grouped into three-byte packets, and a packet start
// is taken only from a byte with bit 3 set, which resynchronizes the stream
// after a lost byte. The cursor is clamped to 0..max_x and 0..max_y at each
// frame end report; set-position values are loaded as given and clamped at
// the next report. Write max_x (address 0) and max_y (address 4) only while
// no item is in flight.
module ps2_mouse_packet_tracker (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,  // data_byte[7:0], new_x[24:8], new_y[41:25], zero pad
  input  logic [1:0]  in_tuser,  // kind[1:0]
  // Result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata, // pos_x, pos_y, delta_x, delta_y, buttons_down,
                                 // buttons_pressed, buttons_released, zero pad
  // Configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  // Configuration registers.
  logic [pmt_pkg::POS_W-1:0] max_x_r, max_y_r;
  logic                      cfg_wr;

  // Input register.
  logic                          in_vld_r;
  pmt_pkg::kind_t                in_kind_r;
  logic [7:0]                    in_byte_r;
  logic signed [pmt_pkg::NEW_W-1:0] in_new_x_r, in_new_y_r;

  // Tracker state and result register.
  pmt_pkg::trk_state_t state_r, state_nxt;
  pmt_pkg::frame_rpt_t rpt_nxt, rpt_r;
  logic                rpt_vld_nxt;
  logic                out_vld_r;

  logic in_xfer, fire;

  // Items that make no report are applied at once; a frame end item waits
  // until the result register is free or being emptied in this same cycle.
  assign fire      = in_vld_r && ((in_kind_r != pmt_pkg::KIND_FRAME_END) ||
                                  !out_vld_r || out_tready);
  assign in_tready = !in_vld_r || fire;
  assign in_xfer   = in_tvalid && in_tready;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = {16'h0000, (cfg_paddr[2] == pmt_pkg::REG_MAX_Y) ? max_y_r : max_x_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_x_r <= pmt_pkg::MAX_X_RST;
      max_y_r <= pmt_pkg::MAX_Y_RST;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == pmt_pkg::REG_MAX_Y) begin
        max_y_r <= cfg_pwdata[pmt_pkg::POS_W-1:0];
      end else begin
        max_x_r <= cfg_pwdata[pmt_pkg::POS_W-1:0];
      end
    end
  end

  // Input register: valid bit under reset, payload loads on each transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_xfer) begin
      in_vld_r <= 1'b1;
    end else if (fire) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_kind_r  <= pmt_pkg::kind_t'(in_tuser);
      in_byte_r  <= in_tdata[7:0];
      in_new_x_r <= in_tdata[24:8];
      in_new_y_r <= in_tdata[41:25];
    end
  end

  pmt_update u_update (
    .cur       (state_r),
    .kind      (in_kind_r),
    .data_byte (in_byte_r),
    .new_x     (in_new_x_r),
    .new_y     (in_new_y_r),
    .max_x     (max_x_r),
    .max_y     (max_y_r),
    .nxt       (state_nxt),
    .rpt_vld   (rpt_vld_nxt),
    .rpt       (rpt_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '{phase: pmt_pkg::PH_HEADER, default: '0};
    end else if (fire) begin
      state_r <= state_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (fire && rpt_vld_nxt) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && rpt_vld_nxt) begin
      rpt_r <= rpt_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {7'b0000000, rpt_r};

`ifndef SYNTHESIS
  // A press edge is always a button that is now down.
  a_press_subset: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.press & ~state_r.levels) == '0)
    else $error("press edge on a button that is up");

  // A release edge is always a button that is now up.
  a_release_subset: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.release_m & state_r.levels) == '0)
    else $error("release edge on a button that is down");

  // Applying a frame end item always leaves a report waiting.
  a_frame_reports: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (in_kind_r == pmt_pkg::KIND_FRAME_END) |=> out_vld_r)
    else $error("frame end item produced no report");

  // Other kinds never create a report out of an empty result register.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (in_kind_r != pmt_pkg::KIND_FRAME_END) && !out_vld_r |=> !out_vld_r)
    else $error("report created by a non-report item");

  // A report sets the delta accumulators back to zero.
  a_frame_clears: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (in_kind_r == pmt_pkg::KIND_FRAME_END) |=>
      (state_r.frame_dx == '0) && (state_r.frame_dy == '0))
    else $error("frame deltas not cleared after report");
`endif

endmodule
